// File: rtl/record_lock_table_top_assert.svh
// assertion macros for the record lock table checker
// expects clk and arst_n in the scope of each use
`ifndef RECORD_LOCK_TABLE_TOP_ASSERT_SVH
`define RECORD_LOCK_TABLE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RLT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define RLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rlt_pkg.sv
// shared types and constants of the record lock table
// no dependencies
package rlt_pkg;

	localparam int TABLE_W  = 10;
	localparam int KEY_W    = 64;
	localparam int REQID_W  = 8;
	localparam int STATUS_W = 3;

	// request kinds
	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// response status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_GRANTED    = 3'd0,
		STAT_WAITING    = 3'd1,
		STAT_REL_NONE   = 3'd2,
		STAT_REL_NEXT   = 3'd3,
		STAT_TABLE_FULL = 3'd4,
		STAT_QUEUE_FULL = 3'd5,
		STAT_NO_HOLDER  = 3'd6
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_EVAL,
		S_WAKE
	} state_t;

endpackage

// File: rtl/rlt_req_if.sv
// request channel of the record lock table
// depends on rlt_pkg
interface rlt_req_if import rlt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [TABLE_W-1:0] tbl_id;
	logic signed [KEY_W-1:0] record_key;
	logic [REQID_W-1:0] requester_id;

	modport source (output valid, req_type, tbl_id, record_key, requester_id, input ready);
	modport sink (input valid, req_type, tbl_id, record_key, requester_id, output ready);
endinterface

// File: rtl/rlt_rsp_if.sv
// response channel of the record lock table
// depends on rlt_pkg
interface rlt_rsp_if import rlt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [REQID_W-1:0]  woken_id;

	modport source (output valid, status, woken_id, input ready);
	modport sink (input valid, status, woken_id, output ready);
endinterface

// File: rtl/record_lock_table_top.sv
// record lock table: exclusive record locks with per-record fifo wait queues
// depends on rlt_pkg, rlt_req_if, rlt_rsp_if
//
// Usage: the req channel carries acquire and release beats (req_type, tbl_id,
// record_key, requester_id); every request gives exactly one rsp beat with
// status and woken_id (woken_id is nonzero only for a release that hands the
// lock to the next waiter). Requests are taken one at a time.
// Flow: after the request beat the sequencer reads the bucket row (READ), then
// evaluates it (EVAL) and loads the response register; a release that wakes a
// waiter also passes through WAKE to read the waiter memory. A new request is
// taken only once the previous one has loaded its response. When BUCKETS is not
// a power of two, the bucket hash is first reduced 4 bits a cycle in HASH.
// Throughput is set by the read-modify-write of the bucket row memory.
// After reset the bucket memory is swept clear, one row a cycle, while
// req.ready stays low. The response sits in an output register; a new request
// is accepted while it waits, but the next result holds in the evaluate or wake
// state until rsp.ready frees the register.
module record_lock_table_top import rlt_pkg::*; #(
	parameter int BUCKETS     = 64,
	parameter int WAYS        = 4,
	parameter int QUEUE_DEPTH = 8
) (
	input logic        clk,
	input logic        arst_n,
	rlt_req_if.sink    req,
	rlt_rsp_if.source  rsp
);

	localparam int  BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int  WYW     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int  HW      = $clog2(QUEUE_DEPTH);
	localparam int  CW      = $clog2(QUEUE_DEPTH + 1);
	localparam int  NSLOT   = BUCKETS * WAYS;
	localparam int  SW      = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam int  WAW     = $clog2(NSLOT * QUEUE_DEPTH);
	localparam bit  IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
	localparam int  EW      = 1 + TABLE_W + KEY_W + HW + CW;
	// entry layout {valid, table, record, head, count}
	localparam int  O_HEAD  = CW;
	localparam int  O_REC   = CW + HW;
	localparam int  O_TAB   = CW + HW + KEY_W;
	localparam int  O_VLD   = EW - 1;
	localparam logic [BW-1:0] BMASK = BW'(BUCKETS - 1);
	localparam logic [BW-1:0] BLAST = BW'(BUCKETS - 1);
	localparam logic [BW:0]   BMOD  = (BW + 1)'(BUCKETS);
	localparam logic [CW-1:0] QD_C  = CW'(QUEUE_DEPTH);
	localparam logic [HW:0]   QD_H  = (HW + 1)'(QUEUE_DEPTH);

	typedef logic [WAYS-1:0][EW-1:0] row_t;

	state_t state_q, state_d;

	// memories
	row_t             row_mem [BUCKETS];
	logic [REQID_W-1:0] wait_mem [NSLOT * QUEUE_DEPTH];
	row_t             row_rd_q;
	logic [REQID_W-1:0] wait_rd_q;

	// request registers
	logic               kind_q;
	logic [TABLE_W-1:0] tab_q;
	logic [KEY_W-1:0]   rec_q;
	logic [REQID_W-1:0] who_q;
	logic [KEY_W-1:0]   sum_q;
	logic [BW-1:0]      bucket_q;
	logic [3:0]         hcnt_q;
	logic [BW-1:0]      clr_q;

	// response register
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [REQID_W-1:0]  woken_q;

	logic out_free;
	logic accept;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.woken_id = woken_q;

	// serial reduction of the key sum, 4 bits a cycle
	logic [BW-1:0] rem_next;
	always_comb begin
		logic [BW:0] t;
		rem_next = bucket_q;
		for (int i = 0; i < 4; i++) begin
			t = {rem_next, sum_q[KEY_W-1-i]};
			if (t >= BMOD) begin
				t = t - BMOD;
			end
			rem_next = t[BW-1:0];
		end
	end

	// way lookup and row update
	logic            hit, has_free;
	logic [WYW-1:0]  hit_way, free_way, way_sel;
	logic [EW-1:0]   ent, ent_new;
	logic [CW-1:0]   ent_cnt;
	logic [HW-1:0]   ent_head;
	logic [HW:0]     pos_sum;
	logic [HW-1:0]   pos;
	logic [HW-1:0]   nhead;
	logic [SW-1:0]   slot;
	logic [WAW-1:0]  wait_addr;
	logic            row_we, wait_we, wait_re, load_rsp;
	status_t         stat_d;
	row_t            row_new;

	always_comb begin
		hit = 1'b0;
		has_free = 1'b0;
		hit_way = '0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_rd_q[w][O_VLD] && row_rd_q[w][O_TAB +: TABLE_W] == tab_q
					&& row_rd_q[w][O_REC +: KEY_W] == rec_q) begin
				hit = 1'b1;
				hit_way = WYW'(w);
			end
			if (!row_rd_q[w][O_VLD]) begin
				has_free = 1'b1;
				free_way = WYW'(w);
			end
		end
	end

	always_comb begin
		way_sel = hit ? hit_way : free_way;
		ent = row_rd_q[way_sel];
		ent_cnt = ent[CW-1:0];
		ent_head = ent[O_HEAD +: HW];
		pos_sum = {1'b0, ent_head} + (HW + 1)'(ent_cnt);
		if (pos_sum >= QD_H) begin
			pos_sum = pos_sum - QD_H;
		end
		pos = pos_sum[HW-1:0];
		nhead = (ent_head == HW'(QUEUE_DEPTH - 1)) ? '0 : ent_head + 1'b1;
		slot = SW'(bucket_q) * SW'(WAYS) + SW'(way_sel);
		ent_new = ent;
		wait_addr = WAW'(slot) * WAW'(QUEUE_DEPTH);
		row_we = 1'b0;
		wait_we = 1'b0;
		wait_re = 1'b0;
		stat_d = STAT_NO_HOLDER;
		if (kind_q == REQ_ACQUIRE) begin
			if (hit) begin
				if (ent_cnt >= QD_C) begin
					stat_d = STAT_QUEUE_FULL;
				end else begin
					ent_new[CW-1:0] = ent_cnt + 1'b1;
					wait_addr = wait_addr + WAW'(pos);
					row_we = 1'b1;
					wait_we = 1'b1;
					stat_d = (ent_cnt == '0) ? STAT_GRANTED : STAT_WAITING;
				end
			end else if (has_free) begin
				ent_new = {1'b1, tab_q, rec_q, HW'(0), CW'(1)};
				row_we = 1'b1;
				wait_we = 1'b1;
				stat_d = STAT_GRANTED;
			end else begin
				stat_d = STAT_TABLE_FULL;
			end
		end else if (hit && ent_cnt != '0) begin
			row_we = 1'b1;
			if (ent_cnt == CW'(1)) begin
				ent_new = '0;
				stat_d = STAT_REL_NONE;
			end else begin
				ent_new[CW-1:0] = ent_cnt - 1'b1;
				ent_new[O_HEAD +: HW] = nhead;
				wait_addr = wait_addr + WAW'(nhead);
				wait_re = 1'b1;
				stat_d = STAT_REL_NEXT;
			end
		end
		row_new = row_rd_q;
		row_new[way_sel] = ent_new;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		load_rsp = 1'b0;
		case (state_q)
			S_CLEAR: if (clr_q == BLAST) state_d = S_IDLE;
			S_IDLE: if (accept) state_d = IS_POW2 ? S_READ : S_HASH;
			S_HASH: if (hcnt_q == 4'hF) state_d = S_READ;
			S_READ: state_d = S_EVAL;
			S_EVAL: begin
				if (wait_re) begin
					state_d = S_WAKE;
				end else if (out_free) begin
					load_rsp = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WAKE: begin
				if (out_free) begin
					load_rsp = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// commit happens once: on the wake path at entry to S_WAKE, else with the response
	logic commit;
	assign commit = (state_q == S_EVAL) && (wait_re || out_free);

	// bucket row memory, one write and one read port
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			row_mem[clr_q] <= '0;
		end else if (commit && row_we) begin
			row_mem[bucket_q] <= row_new;
		end
		if (state_q == S_READ) begin
			row_rd_q <= row_mem[bucket_q];
		end
	end

	// waiter id memory
	always_ff @(posedge clk) begin
		if (commit && wait_we) begin
			wait_mem[wait_addr] <= who_q;
		end
		if (commit && wait_re) begin
			wait_rd_q <= wait_mem[wait_addr];
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			hcnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_HASH) begin
				hcnt_q <= hcnt_q + 1'b1;
			end else begin
				hcnt_q <= '0;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.req_type;
			tab_q <= req.tbl_id;
			rec_q <= req.record_key;
			who_q <= req.requester_id;
			sum_q <= KEY_W'(req.tbl_id) + req.record_key;
			bucket_q <= IS_POW2
				? BW'(KEY_W'(req.tbl_id) + req.record_key) & BMASK
				: '0;
		end else if (state_q == S_HASH) begin
			sum_q <= {sum_q[KEY_W-5:0], 4'b0};
			bucket_q <= rem_next;
		end
		if (load_rsp) begin
			status_q <= (state_q == S_WAKE) ? STAT_REL_NEXT : stat_d;
			woken_q <= (state_q == S_WAKE) ? wait_rd_q : '0;
		end
	end

endmodule

// File: rtl/rlt_checker.sv
// port-level checker for the record lock table, bound to the top level
// depends on rlt_pkg and record_lock_table_top_assert.svh
`include "record_lock_table_top_assert.svh"
module rlt_checker import rlt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [REQID_W-1:0]  woken_id
);

	// a stalled response beat stays put
	`RLT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(woken_id), "response changed while stalled")
	// only a hand-over release names a woken requester
	`RLT_ASSERT_NOW(a_woken_status, rsp_valid && woken_id != '0, status == STAT_REL_NEXT, "woken id without hand-over")
	// status code is in range
	`RLT_ASSERT_NOW(a_status_range, rsp_valid, status <= STAT_NO_HOLDER, "status out of range")
	// one request at a time
	`RLT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

endmodule

bind record_lock_table_top rlt_checker u_rlt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status   (rsp.status),
	.woken_id (rsp.woken_id)
);
